// File: src/pfda_pkg.sv
// Shared types, constants and the fixed permutation table for the PID
// feedback drop admission block. No dependencies.
package pfda_pkg;

  // Length of the request permutation table and the width of its index.
  localparam int unsigned TABLE_LEN = 100;
  localparam int unsigned PHASE_W   = $clog2(TABLE_LEN);

  // Default depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Field widths.
  localparam int unsigned LOAD_W  = 16;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned DIF_W   = 18;
  localparam int unsigned INTEG_W = 32;
  localparam int unsigned RATE_W  = 8;
  localparam int unsigned CIDX_W  = 2;

  // Products of the gains with the error terms.
  localparam int unsigned PROD_P_W = GAIN_W + ERR_W;
  localparam int unsigned PROD_I_W = GAIN_W + INTEG_W;
  localparam int unsigned PROD_D_W = GAIN_W + DIF_W;
  localparam int unsigned SUM_W    = PROD_I_W + 2;
  localparam int unsigned FRAC_W   = 23;

  // Reset value of the integral gain: -25.0 with 8 fraction bits.
  localparam logic signed [GAIN_W-1:0] GAIN_I_RESET = -24'sd6400;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_SAMPLE  = 1'b1
  } op_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SETPOINT = 2'd0,
    CFG_GAIN_P   = 2'd1,
    CFG_GAIN_I   = 2'd2,
    CFG_GAIN_D   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
  } pfda_gains_t;

  // One classified item as it travels from the front to the back part.
  typedef struct packed {
    op_e                       op;
    logic signed [ERR_W-1:0]   err;
    logic signed [DIF_W-1:0]   dif;
    logic signed [INTEG_W-1:0] integ;
  } pfda_entry_t;

  localparam logic [PHASE_W-1:0] PERM_TABLE [TABLE_LEN] = '{
    7'd18, 7'd50, 7'd51, 7'd39, 7'd49, 7'd68, 7'd8,  7'd78, 7'd61, 7'd75,
    7'd53, 7'd32, 7'd45, 7'd77, 7'd31, 7'd12, 7'd26, 7'd10, 7'd37, 7'd99,
    7'd29, 7'd0,  7'd52, 7'd82, 7'd91, 7'd22, 7'd7,  7'd42, 7'd87, 7'd43,
    7'd73, 7'd86, 7'd70, 7'd69, 7'd13, 7'd60, 7'd24, 7'd25, 7'd6,  7'd93,
    7'd96, 7'd97, 7'd84, 7'd47, 7'd79, 7'd64, 7'd90, 7'd81, 7'd4,  7'd15,
    7'd63, 7'd44, 7'd57, 7'd40, 7'd21, 7'd28, 7'd46, 7'd94, 7'd35, 7'd58,
    7'd11, 7'd30, 7'd3,  7'd20, 7'd41, 7'd74, 7'd34, 7'd88, 7'd62, 7'd54,
    7'd33, 7'd92, 7'd76, 7'd85, 7'd5,  7'd72, 7'd9,  7'd83, 7'd56, 7'd17,
    7'd95, 7'd55, 7'd80, 7'd98, 7'd66, 7'd14, 7'd16, 7'd38, 7'd71, 7'd23,
    7'd2,  7'd67, 7'd36, 7'd65, 7'd27, 7'd1,  7'd19, 7'd59, 7'd89, 7'd48
  };

  // Table read; an index past the end falls back to the first entry.
  function automatic logic [PHASE_W-1:0] perm_lookup(input logic [PHASE_W-1:0] idx);
    logic [PHASE_W-1:0] val;
    if (idx < PHASE_W'(TABLE_LEN)) begin
      val = PERM_TABLE[idx];
    end else begin
      val = PERM_TABLE[0];
    end
    return val;
  endfunction

endpackage

// File: src/pfda_front.sv
// Front part: accepts items, classifies them and runs the error and
// integral update of the PID step. Depends on pfda_pkg.
module pfda_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pfda_pkg::LOAD_W-1:0]   setpoint_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [pfda_pkg::LOAD_W-1:0]   load_sample_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output pfda_pkg::pfda_entry_t         q_entry_o
);
  import pfda_pkg::*;

  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [ERR_W-1:0]   prev_err_q, prev_err_d;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIF_W-1:0]   dif;
  logic        [INTEG_W:0]   acc;
  logic signed [INTEG_W-1:0] integ_sat;
  logic                      is_sample;
  logic                      accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;
  assign is_sample  = (op_e'(opcode_i) == OP_SAMPLE);

  assign err = ERR_W'({1'b0, setpoint_i}) - ERR_W'({1'b0, load_sample_i});
  assign dif = {err[ERR_W-1], err} - {prev_err_q[ERR_W-1], prev_err_q};
  assign acc = {integ_q[INTEG_W-1], integ_q}
             + {{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};

  // Saturate the integral at the signed 32-bit limits.
  always_comb begin
    if (acc[INTEG_W] != acc[INTEG_W-1]) begin
      integ_sat = acc[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_sat = acc[INTEG_W-1:0];
    end
  end

  always_comb begin
    integ_d    = integ_q;
    prev_err_d = prev_err_q;
    if (accept && is_sample) begin
      prev_err_d = err;
      // The integral only winds while it or the error is negative.
      if (integ_q[INTEG_W-1] || err[ERR_W-1]) begin
        integ_d = integ_sat;
      end
    end
  end

  always_comb begin
    q_entry_o.op    = is_sample ? OP_SAMPLE : OP_REQUEST;
    q_entry_o.err   = err;
    q_entry_o.dif   = dif;
    q_entry_o.integ = integ_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      prev_err_q <= '0;
    end else begin
      integ_q    <= integ_d;
      prev_err_q <= prev_err_d;
    end
  end

endmodule

// File: src/pfda_queue.sv
// Short first-in first-out queue of classified items between the front and
// back parts. Depends on pfda_pkg.
module pfda_queue #(
  parameter int unsigned Depth = pfda_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pfda_pkg::pfda_entry_t push_entry_i,
  output logic                  full_o,
  output logic                  valid_o,
  output pfda_pkg::pfda_entry_t entry_o,
  input  logic                  pop_i
);
  import pfda_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pfda_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == PtrW'(Depth - 1)) begin
      n = '0;
    end else begin
      n = p + PtrW'(1);
    end
    return n;
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: src/pfda_back.sv
// Back part: gain multiplies, sum and clamp to the drop rate, and the request
// phase counter with its permutation compare. Depends on pfda_pkg.
module pfda_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pfda_pkg::pfda_gains_t           gains_i,
  input  logic                            q_valid_i,
  input  pfda_pkg::pfda_entry_t           q_entry_i,
  output logic                            q_pop_o,
  output logic                            stage_valid_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            drop_o,
  output logic [pfda_pkg::RATE_W-1:0]     drop_rate_now_o
);
  import pfda_pkg::*;

  // Multiply stage.
  logic                       a_valid_q, a_valid_d;
  op_e                        a_op_q;
  logic signed [PROD_P_W-1:0] prod_p_q, prod_p_d;
  logic signed [PROD_I_W-1:0] prod_i_q, prod_i_d;
  logic signed [PROD_D_W-1:0] prod_d_q, prod_d_d;
  logic signed [GAIN_W-1:0]   gp, gi, gd;
  logic signed [ERR_W-1:0]    e;
  logic signed [INTEG_W-1:0]  ig;
  logic signed [DIF_W-1:0]    df;

  // Result stage and controller state.
  logic                       out_valid_q, out_valid_d;
  logic                       drop_q, drop_d;
  logic [RATE_W-1:0]          res_rate_q, res_rate_d;
  logic [RATE_W-1:0]          rate_q, rate_d;
  logic [PHASE_W-1:0]         phase_q, phase_d, phase_nxt;
  logic signed [SUM_W-1:0]    sum;
  logic [SUM_W-FRAC_W-1:0]    quot;
  logic [RATE_W-1:0]          rate_new;
  logic                       out_adv, a_ready, a_fire;

  assign out_adv = !out_valid_q || !out_stall_i;
  assign a_ready = !a_valid_q || out_adv;
  assign q_pop_o = q_valid_i && a_ready;
  assign a_fire  = a_valid_q && out_adv;

  assign gp = gains_i.gain_p;
  assign gi = gains_i.gain_i;
  assign gd = gains_i.gain_d;
  assign e  = q_entry_i.err;
  assign ig = q_entry_i.integ;
  assign df = q_entry_i.dif;

  assign prod_p_d = gp * e;
  assign prod_i_d = gi * ig;
  assign prod_d_d = gd * df;

  assign a_valid_d = a_ready ? q_valid_i : a_valid_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      a_op_q   <= q_entry_i.op;
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
    end
  end

  // Sum the three products exactly, drop the fraction bits, then clamp to 0..255.
  assign sum = {{(SUM_W-PROD_P_W){prod_p_q[PROD_P_W-1]}}, prod_p_q}
             + {{(SUM_W-PROD_I_W){prod_i_q[PROD_I_W-1]}}, prod_i_q}
             + {{(SUM_W-PROD_D_W){prod_d_q[PROD_D_W-1]}}, prod_d_q};
  assign quot = sum[SUM_W-1:FRAC_W];

  always_comb begin
    if (sum[SUM_W-1] || (sum == '0)) begin
      rate_new = '0;
    end else if (|quot[SUM_W-FRAC_W-1:RATE_W]) begin
      rate_new = '1;
    end else begin
      rate_new = quot[RATE_W-1:0];
    end
  end

  assign phase_nxt = (phase_q == PHASE_W'(TABLE_LEN - 1)) ? '0 : phase_q + PHASE_W'(1);

  always_comb begin
    out_valid_d = out_adv ? a_valid_q : out_valid_q;
    drop_d      = drop_q;
    res_rate_d  = res_rate_q;
    rate_d      = rate_q;
    phase_d     = phase_q;
    if (a_fire) begin
      unique case (a_op_q)
        OP_SAMPLE: begin
          rate_d     = rate_new;
          drop_d     = 1'b0;
          res_rate_d = rate_new;
        end
        OP_REQUEST: begin
          phase_d    = phase_nxt;
          drop_d     = ({1'b0, perm_lookup(phase_nxt)} < rate_q);
          res_rate_d = rate_q;
        end
        default: begin
          drop_d     = 1'b0;
          res_rate_d = rate_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      rate_q      <= '0;
      phase_q     <= '0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      rate_q      <= rate_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drop_q     <= drop_d;
    res_rate_q <= res_rate_d;
  end

  assign stage_valid_o   = a_valid_q;
  assign out_valid_o     = out_valid_q;
  assign drop_o          = drop_q;
  assign drop_rate_now_o = res_rate_q;

endmodule

// File: src/pid_feedback_drop_admission_top.sv
// Top level of the PID feedback drop admission block: configuration
// registers, front part, queue and back part. Depends on pfda_pkg.
module pid_feedback_drop_admission_top #(
  parameter int unsigned QueueDepth = pfda_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pfda_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [pfda_pkg::GAIN_W-1:0]   cfg_data_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [pfda_pkg::LOAD_W-1:0]   load_sample_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          drop_o,
  output logic [pfda_pkg::RATE_W-1:0]   drop_rate_now_o
);
  // The block admits or drops requests against a drop rate that a PID loop
  // sets from load samples. Every accepted item gives exactly one result, in
  // order. A load sample updates the error, the saturating integral and the
  // previous error as it is accepted, then the gain products are formed in a
  // multiply stage and summed, shifted and clamped to 0..255 in the result
  // stage; its result carries the new rate and drop low. A request advances
  // the phase counter modulo 100 in the result stage and is dropped when the
  // permutation value at the new phase is below the rate at that moment, so
  // a request always sees the rate left by every sample before it. The block
  // sustains one item per clock cycle in any mix of samples and requests
  // while the result side does not stall, as the integral is updated on
  // accept and the back part has one multiply stage. An item passes the
  // queue, the multiply stage and the result register before its result
  // is valid. The input is stalled only when the queue between the two
  // parts is full, that is when the result register, the multiply stage
  // and the queue together hold QueueDepth plus two requests behind a
  // stalled result side; with the default depth of two and requests
  // arriving every cycle, a single cycle of stall on the result side fills it.
  // Configuration writes are always taken (ready is held high) and must only
  // be issued while no request is in flight.
  import pfda_pkg::*;

  logic [LOAD_W-1:0] setpoint_q, setpoint_d;
  pfda_gains_t       gains_q, gains_d;
  logic              cfg_write;

  logic              q_push, q_full, q_valid, q_pop;
  pfda_entry_t       q_push_entry, q_entry;
  logic              stage_valid;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    setpoint_d = setpoint_q;
    gains_d    = gains_q;
    if (cfg_write) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SETPOINT: setpoint_d     = cfg_data_i[LOAD_W-1:0];
        CFG_GAIN_P:   gains_d.gain_p = cfg_data_i;
        CFG_GAIN_I:   gains_d.gain_i = cfg_data_i;
        CFG_GAIN_D:   gains_d.gain_d = cfg_data_i;
        default: begin
          setpoint_d = setpoint_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q     <= '0;
      gains_q.gain_p <= '0;
      gains_q.gain_i <= GAIN_I_RESET;
      gains_q.gain_d <= '0;
    end else begin
      setpoint_q <= setpoint_d;
      gains_q    <= gains_d;
    end
  end

  pfda_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .setpoint_i    (setpoint_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .load_sample_i (load_sample_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_push_entry)
  );

  pfda_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .full_o       (q_full),
    .valid_o      (q_valid),
    .entry_o      (q_entry),
    .pop_i        (q_pop)
  );

  pfda_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .gains_i         (gains_q),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_entry),
    .q_pop_o         (q_pop),
    .stage_valid_o   (stage_valid),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drop_o          (drop_o),
    .drop_rate_now_o (drop_rate_now_o)
  );

  // A dropped request needs a non-zero rate: no table value is below zero.
  a_drop_needs_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && drop_o) |-> (drop_rate_now_o != '0))
    else $error("request dropped while the drop rate is zero");

  // With the queue and the multiply stage empty and the result register free,
  // no result may appear in the next cycle.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_valid && !stage_valid && (!out_valid_o || !out_stall_i)) |=> !out_valid_o)
    else $error("result produced with nothing in flight");

  // The queue is never popped while empty nor pushed while full.
  a_queue_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && !q_valid) && !(q_push && q_full))
    else $error("queue overrun or underrun");

endmodule

// File: bench/pid_feedback_drop_admission_top_tb.sv
// Self-checking testbench for pid_feedback_drop_admission_top: a queue-fed
// driver, a predictor of the PID drop-rate loop and a result monitor.
// Depends on pfda_pkg and the top level of the block.
module pid_feedback_drop_admission_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfda_pkg::*;

  // Cycles the driver lets pass after the last result before it writes a
  // register, and cycles watched for stray results at the very end.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  // Generous bound on the whole run.
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned REPORT_MAX    = 10;

  // Saturation bounds of the error integral.
  localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 64'sd1;
  localparam longint INTEG_MIN = -(64'sd1 <<< (INTEG_W - 1));

  // What the driver does with one queue entry: present an input request,
  // write a register, or hold off until every expected result has come.
  typedef enum logic [1:0] {
    ST_ITEM,
    ST_WRITE,
    ST_DRAIN
  } stim_kind_e;

  typedef struct {
    stim_kind_e  kind;
    op_e         op;
    logic [LOAD_W-1:0] load;
    cfg_idx_e    idx;
    logic [GAIN_W-1:0] data;
    int unsigned gap;
  } stim_t;

  // Expected verdict for one result request.
  typedef struct packed {
    logic              drop;
    logic [RATE_W-1:0] rate;
  } verdict_t;

  // Clock and reset.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Block inputs, all at known values from the first instant.
  logic                cfg_valid = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [GAIN_W-1:0]   cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                opcode    = 1'b0;
  logic [LOAD_W-1:0]   load      = '0;
  logic                out_stall = 1'b0;

  // Block outputs.
  logic                cfg_ready;
  logic                in_stall;
  logic                out_valid;
  logic                drop;
  logic [RATE_W-1:0]   drop_rate_now;

  // Handshake outcomes captured at the rising edge, used at the falling one.
  logic in_taken  = 1'b0;
  logic cfg_taken = 1'b0;
  logic out_taken = 1'b0;

  // Stimulus queue and driver state.
  stim_t       pend_q[$];
  stim_t       cur;
  logic        have_cur    = 1'b0;
  logic        in_busy     = 1'b0;
  logic        cfg_busy    = 1'b0;
  logic        stim_done   = 1'b0;
  int unsigned wait_left   = 0;
  int unsigned settle_left = 0;

  // Receiver state.
  int unsigned hold_left  = 0;
  int unsigned burst_left = 0;

  // Predictor state: register copies and the controller's own state.
  logic [LOAD_W-1:0]        setpoint_r = '0;
  logic signed [GAIN_W-1:0] gain_p_r   = '0;
  logic signed [GAIN_W-1:0] gain_i_r   = GAIN_I_RESET;
  logic signed [GAIN_W-1:0] gain_d_r   = '0;
  longint                   integ_r    = 0;
  longint                   prev_err_r = 0;
  logic [RATE_W-1:0]        rate_r     = '0;
  int unsigned              phase_r    = 0;

  verdict_t verdict_q[$];

  // Bookkeeping.
  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;
  int unsigned n_checked   = 0;
  int unsigned n_admit     = 0;
  int unsigned n_samples   = 0;
  int unsigned n_drops     = 0;
  int unsigned n_writes    = 0;
  int unsigned n_sat       = 0;

  pid_feedback_drop_admission_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .load_sample_i   (load),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .drop_o          (drop),
    .drop_rate_now_o (drop_rate_now)
  );

  // 12 ns period: the clock flips every 6 ns.
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Mirrors a register write. The index is two bits wide, so every value
  // names a register; the default arm only keeps the case complete.
  task automatic write_register(input logic [CIDX_W-1:0] idx,
                                input logic [GAIN_W-1:0] data);
    case (cfg_idx_e'(idx))
      CFG_SETPOINT: setpoint_r = data[LOAD_W-1:0];
      CFG_GAIN_P:   gain_p_r   = data;
      CFG_GAIN_I:   gain_i_r   = data;
      CFG_GAIN_D:   gain_d_r   = data;
      default: ;
    endcase
  endtask

  // Works out the verdict for one accepted input request and moves the
  // controller state on. A load sample runs one PID step; an admission
  // request steps the phase and compares the table entry with the rate.
  task automatic step_controller(input op_e op, input logic [LOAD_W-1:0] sample,
                                 output logic drop_exp,
                                 output logic [RATE_W-1:0] rate_exp);
    longint sp, ld, gp, gi, gd, err, dif, acc, sum, q;
    drop_exp = 1'b0;
    if (op == OP_SAMPLE) begin
      sp  = setpoint_r;
      ld  = sample;
      gp  = gain_p_r;
      gi  = gain_i_r;
      gd  = gain_d_r;
      err = sp - ld;
      dif = err - prev_err_r;
      // The integral only moves while it, or the new error, is negative.
      if (integ_r < 0 || err < 0) begin
        acc = integ_r + err;
        if (acc > INTEG_MAX) begin
          acc = INTEG_MAX;
          n_sat++;
        end else if (acc < INTEG_MIN) begin
          acc = INTEG_MIN;
          n_sat++;
        end
        integ_r = acc;
      end
      sum = gp * err + gi * integ_r + gd * dif;
      prev_err_r = err;
      if (sum <= 0) begin
        rate_r = '0;
      end else begin
        q = sum >>> FRAC_W;
        rate_r = (q > 255) ? 8'd255 : RATE_W'(q);
      end
    end else begin
      phase_r  = (phase_r + 1 >= TABLE_LEN) ? 0 : phase_r + 1;
      drop_exp = (PERM_TABLE[phase_r] < rate_r);
    end
    rate_exp = rate_r;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------

  task automatic push_item(input op_e op, input logic [LOAD_W-1:0] sample,
                           input int unsigned gap);
    stim_t s;
    s.kind = ST_ITEM;
    s.op   = op;
    s.load = sample;
    s.idx  = CFG_SETPOINT;
    s.data = '0;
    s.gap  = gap;
    pend_q.push_back(s);
  endtask

  task automatic push_drain();
    stim_t s;
    s.kind = ST_DRAIN;
    s.op   = OP_REQUEST;
    s.load = '0;
    s.idx  = CFG_SETPOINT;
    s.data = '0;
    s.gap  = 0;
    pend_q.push_back(s);
  endtask

  // Waits for the block to go idle, then writes all four registers in
  // index order with short random pauses between the writes.
  task automatic push_settings(input logic [GAIN_W-1:0] sp_word,
                               input logic [GAIN_W-1:0] gp,
                               input logic [GAIN_W-1:0] gi,
                               input logic [GAIN_W-1:0] gd);
    stim_t s;
    push_drain();
    s.kind = ST_WRITE;
    s.op   = OP_REQUEST;
    s.load = '0;
    s.idx  = CFG_SETPOINT;
    s.data = sp_word;
    s.gap  = $urandom_range(0, 3);
    pend_q.push_back(s);
    s.idx  = CFG_GAIN_P;
    s.data = gp;
    s.gap  = $urandom_range(0, 3);
    pend_q.push_back(s);
    s.idx  = CFG_GAIN_I;
    s.data = gi;
    s.gap  = $urandom_range(0, 3);
    pend_q.push_back(s);
    s.idx  = CFG_GAIN_D;
    s.data = gd;
    s.gap  = $urandom_range(0, 3);
    pend_q.push_back(s);
  endtask

  // Gains: the full signed range, its two ends, zero, and the moderate
  // magnitudes that give drop rates in the useful percent range.
  function automatic logic [GAIN_W-1:0] pick_gain();
    logic [GAIN_W-1:0] g;
    case ($urandom_range(0, 5))
      0:       g = GAIN_W'($urandom());
      1:       g = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      2:       g = '0;
      3:       g = GAIN_W'($urandom_range(0, 65535));
      default: g = GAIN_W'(-int'($urandom_range(0, 32000)));
    endcase
    return g;
  endfunction

  // Loads: anywhere in the 16-bit field, within full scale, close to the
  // setpoint so that the error stays small, or at zero, full scale or all ones.
  function automatic logic [LOAD_W-1:0] pick_load(input logic [LOAD_W-1:0] sp);
    logic [LOAD_W-1:0] v;
    case ($urandom_range(0, 4))
      0:       v = LOAD_W'($urandom());
      1:       v = LOAD_W'($urandom_range(0, 32768));
      2, 3:    v = sp + LOAD_W'($urandom_range(0, 4096)) - LOAD_W'(2048);
      default: begin
        case ($urandom_range(0, 2))
          0:       v = '0;
          1:       v = 16'd32768;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: works through the queue at the falling edge. A presented
  // request is held unchanged until the rising edge that accepts it.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_busy && in_taken) begin
        in_busy  = 1'b0;
        have_cur = 1'b0;
      end
      if (cfg_busy && cfg_taken) begin
        cfg_busy = 1'b0;
        have_cur = 1'b0;
      end
      if (!have_cur && pend_q.size() > 0) begin
        cur         = pend_q.pop_front();
        have_cur    = 1'b1;
        wait_left   = cur.gap;
        settle_left = SETTLE_CYCLES;
      end
      if (have_cur && !in_busy && !cfg_busy) begin
        if (wait_left > 0) begin
          wait_left--;
        end else begin
          case (cur.kind)
            ST_ITEM: begin
              in_busy = 1'b1;
              opcode <= cur.op;
              load   <= cur.load;
            end
            ST_WRITE: begin
              cfg_busy = 1'b1;
              cfg_index <= cur.idx;
              cfg_data  <= cur.data;
            end
            default: begin
              // Hold-off: every expected result in, then a settling wait so that
              // nothing is left in flight.
              if (verdict_q.size() != 0) begin
                settle_left = SETTLE_CYCLES;
              end else if (settle_left > 0) begin
                settle_left--;
              end else begin
                have_cur = 1'b0;
              end
            end
          endcase
        end
      end
      if (!have_cur && pend_q.size() == 0) begin
        stim_done <= 1'b1;
      end
    end
    in_valid  <= in_busy;
    cfg_valid <= cfg_busy;
  end

  // ---------------------------------------------------------------------
  // Receiver: after each result it draws a random stall, and now and then
  // takes a long run of results without stalling at all.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (out_taken) begin
      if (burst_left > 0) begin
        burst_left--;
        hold_left = 0;
      end else begin
        if ($urandom_range(0, 39) == 0) begin
          burst_left = 60;
        end
        hold_left = $urandom_range(0, 9);
      end
    end else if (hold_left > 0) begin
      hold_left--;
    end
    out_stall <= (hold_left != 0);
  end

  // ---------------------------------------------------------------------
  // Monitor: at the rising edge it mirrors register writes, predicts the
  // verdict of every accepted input request and checks every accepted
  // result against the oldest verdict still waiting.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t          want;
    logic              exp_drop;
    logic [RATE_W-1:0] exp_rate;
    in_taken  <= rst_n && in_valid && !in_stall;
    cfg_taken <= rst_n && cfg_valid && cfg_ready;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (cfg_valid && cfg_ready) begin
        write_register(cfg_index, cfg_data);
        n_writes++;
      end
      if (in_valid && !in_stall) begin
        step_controller(op_e'(opcode), load, exp_drop, exp_rate);
        verdict_q.push_back(verdict_t'{exp_drop, exp_rate});
        if (op_e'(opcode) == OP_SAMPLE) begin
          n_samples++;
        end else begin
          n_admit++;
        end
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("Cycle %0d: result with nothing expected (drop %0b, rate %0d)",
                     cycle_count, drop, drop_rate_now);
          end
        end else begin
          want = verdict_q.pop_front();
          n_checked++;
          if (drop === 1'b1) begin
            n_drops++;
          end
          if (drop !== want.drop || drop_rate_now !== want.rate) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("Cycle %0d: drop expected %0b got %0b, rate expected %0d got %0d",
                       cycle_count, want.drop, drop, want.rate, drop_rate_now);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [LOAD_W-1:0] sp;
    logic [GAIN_W-1:0] sp_word;
    op_e               op;
    logic              burst;
    int unsigned       ph;
    int unsigned       k;

    // Directed part, reset settings first: setpoint 0 and integral gain
    // -25.0. A load above full scale drives the integral negative and
    // lifts the rate, after which some admission requests are dropped.
    push_item(OP_REQUEST, 16'h0000, 0);
    push_item(OP_SAMPLE,  16'h0000, 1);
    push_item(OP_SAMPLE,  16'hFFFF, 0);
    push_item(OP_REQUEST, 16'hFFFF, 2);
    push_item(OP_REQUEST, 16'h0000, 0);
    push_item(OP_SAMPLE,  16'h8000, 0);
    push_item(OP_REQUEST, 16'h5A5A, 3);

    // Gain ends: the proportional term is outweighed by a large negative
    // derivative, so the output goes negative and the rate falls to zero;
    // then the derivative alone saturates the rate, dropping everything.
    push_settings(24'h008000, 24'h7FFFFF, 24'h000000, 24'h800000);
    push_item(OP_SAMPLE,  16'h0000, 0);
    push_item(OP_SAMPLE,  16'h8000, 0);
    push_item(OP_REQUEST, 16'hA5A5, 0);
    push_item(OP_REQUEST, 16'h0000, 1);
    push_item(OP_SAMPLE,  16'hFFFF, 0);

    // Setpoint above full scale, written with the upper data bits set,
    // and the opposite gain ends. A zero load gives the largest error.
    push_settings(24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
    push_item(OP_SAMPLE,  16'h0000, 0);
    push_item(OP_SAMPLE,  16'hFFFF, 0);
    push_item(OP_REQUEST, 16'hFFFF, 0);
    push_item(OP_SAMPLE,  16'h8000, 2);
    push_item(OP_REQUEST, 16'h0000, 0);

    // Ordinary operating point: gain 100.0 and the default integral gain.
    push_settings(24'h000000, 24'h006400, GAIN_I_RESET, 24'h000000);
    push_item(OP_SAMPLE,  16'h0000, 0);
    push_item(OP_REQUEST, 16'h1234, 0);
    push_item(OP_SAMPLE,  16'hFFFF, 0);
    push_item(OP_REQUEST, 16'h0000, 0);
    push_item(OP_REQUEST, 16'hFFFF, 0);

    // Random part: several register settings, each followed by a mix of
    // admission requests and load samples. Some phases run without any
    // gaps, and now and then the sender waits for the block to go idle.
    for (ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0:       sp = '0;
        1:       sp = 16'd32768;
        2:       sp = LOAD_W'($urandom_range(0, 32768));
        default: sp = LOAD_W'($urandom());
      endcase
      sp_word = {8'($urandom()), sp};
      push_settings(sp_word, pick_gain(), pick_gain(), pick_gain());
      burst = ($urandom_range(0, 3) == 0);
      for (k = 0; k < 165; k++) begin
        if (k > 0 && k % 55 == 0 && $urandom_range(0, 1) == 1) begin
          push_drain();
        end
        op = ($urandom_range(0, 99) < 65) ? OP_REQUEST : OP_SAMPLE;
        push_item(op, (op == OP_SAMPLE) ? pick_load(sp) : LOAD_W'($urandom()),
                  burst ? 0 : $urandom_range(0, 9));
      end
    end
    push_drain();

    // Reset is held low from time zero and released at a falling edge.
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    while (!(stim_done && verdict_q.size() == 0) && cycle_count < CYCLE_LIMIT) begin
      @(negedge clk);
    end

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, verdict_q.size());
      $display("Verification failed");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      $display("Summary: %0d admission requests (%0d dropped) and %0d load samples, %0d results checked",
               n_admit, n_drops, n_samples, n_checked);
      $display("Summary: %0d register writes, integral clamped at its limit on %0d steps, %0d mismatches",
               n_writes, n_sat, mismatches);
      if (mismatches == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule
